FILE: rtl/core/cpu_6502_execute_unit_macros.svh
// Assertion macros for the 6502 execute unit.
`ifndef CPU_6502_EXECUTE_UNIT_MACROS_SVH
`define CPU_6502_EXECUTE_UNIT_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define EU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check that an implication holds in the next cycle.
`define EU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/c6502eu_pkg.sv
// Package for the 6502 execute unit: payload types, opcodes, constants.
package c6502eu_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam logic [15:0] STACK_BASE = 16'h0100;

    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_U = 8'h20;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BMI = 6'd6,  OP_BNE = 6'd7,
        OP_BVC = 6'd8,  OP_BVS = 6'd9,  OP_BPL = 6'd10, OP_CLC = 6'd11,
        OP_CLD = 6'd12, OP_CLI = 6'd13, OP_CLV = 6'd14, OP_CMP = 6'd15,
        OP_CPX = 6'd16, OP_CPY = 6'd17, OP_DEC = 6'd18, OP_DEX = 6'd19,
        OP_DEY = 6'd20, OP_EOR = 6'd21, OP_INC = 6'd22, OP_INX = 6'd23,
        OP_INY = 6'd24, OP_JMP = 6'd25, OP_JSR = 6'd26, OP_LDA = 6'd27,
        OP_LDX = 6'd28, OP_LDY = 6'd29, OP_LSR = 6'd30, OP_ORA = 6'd31,
        OP_NOP = 6'd32, OP_PHA = 6'd33, OP_PHP = 6'd34, OP_PLA = 6'd35,
        OP_PLP = 6'd36, OP_ROL = 6'd37, OP_ROR = 6'd38, OP_SEC = 6'd39,
        OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43,
        OP_STY = 6'd44, OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47,
        OP_TXA = 6'd48, OP_TXS = 6'd49, OP_TYA = 6'd50
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PULL,
        ST_JSR
    } state_t;

    typedef struct packed {
        logic [5:0]  op;
        logic [7:0]  operand;
        logic [15:0] address;
        logic [15:0] next_pc_in;
        logic        on_accumulator;
    } in_item_t;

    typedef struct packed {
        logic        mem_write;
        logic [7:0]  mem_data;
        logic [15:0] pc_out;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  flags_out;
    } out_item_t;

endpackage

FILE: rtl/core/c6502eu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module c6502eu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/core/cpu_6502_execute_unit.sv
// Top level of the 6502 execute unit: register file, stack RAM and result stage.
// A result appears in the cycle after its item is accepted; PLA, PLP, JSR
// first wait in ST_PULL or ST_JSR. Throughput: one item per cycle unless the
// output stalls; PLA/PLP wait for the stack RAM read, JSR makes two pushes via
// the single RAM write port. After reset a clearing pass zeroes the stack RAM;
// no item is accepted during it. A, X, Y reset to 0, SP to 0xFF, status to 0x20.
`include "cpu_6502_execute_unit_macros.svh"
module cpu_6502_execute_unit #(
    parameter int STACK_DEPTH = c6502eu_pkg::STACK_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  c6502eu_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output c6502eu_pkg::out_item_t m_data
);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0] acc_reg, x_reg, y_reg, sp_reg, flags_reg;
    logic [7:0] acc_next, x_next, y_next, sp_next, flags_next;
    c6502eu_pkg::state_t state_reg, state_next;
    logic [AW:0] clr_reg;
    logic clearing;

    c6502eu_pkg::in_item_t hold_reg;
    c6502eu_pkg::out_item_t res_next;
    logic out_valid_reg;
    c6502eu_pkg::out_item_t out_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic accept, out_free, finish;
    logic [7:0] sp_inc;
    logic [15:0] ret_pc;

    assign clearing = !clr_reg[AW];
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !clearing && state_reg == c6502eu_pkg::ST_RUN && out_free;
    assign accept   = s_valid && s_ready;
    assign sp_inc   = sp_reg + 8'd1;
    assign ret_pc   = hold_reg.next_pc_in - 16'd1;

    c6502eu_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            c6502eu_pkg::ST_RUN: begin
                if (accept) begin
                    if (s_data.op == c6502eu_pkg::OP_PLA || s_data.op == c6502eu_pkg::OP_PLP) begin
                        state_next = c6502eu_pkg::ST_PULL;
                    end else if (s_data.op == c6502eu_pkg::OP_JSR) begin
                        state_next = c6502eu_pkg::ST_JSR;
                    end
                end
            end
            c6502eu_pkg::ST_PULL, c6502eu_pkg::ST_JSR: begin
                if (out_free) state_next = c6502eu_pkg::ST_RUN;
            end
            default: state_next = c6502eu_pkg::ST_RUN;
        endcase
    end

    // Execute and stack port control
    always_comb begin
        logic [8:0] sum;
        logic [7:0] v, r, res8, m;
        logic       take, cin;
        c6502eu_pkg::in_item_t d;

        d          = (state_reg == c6502eu_pkg::ST_RUN) ? s_data : hold_reg;
        m          = d.operand;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sp_next    = sp_reg;
        flags_next = flags_reg;
        res_next   = '0;
        res_next.pc_out = d.next_pc_in;
        take       = 1'b0;
        cin        = flags_reg[0];
        sum        = '0;
        v          = '0;
        r          = '0;
        res8       = '0;
        ram_we     = 1'b0;
        ram_waddr  = sp_reg[AW-1:0];
        ram_wdata  = '0;
        ram_raddr  = sp_inc[AW-1:0];
        finish     = 1'b0;

        if (clearing) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg[AW-1:0];
        end else if (state_reg == c6502eu_pkg::ST_PULL) begin
            finish = out_free;
            if (out_free) begin
                sp_next = sp_inc;
                if (d.op == c6502eu_pkg::OP_PLA) begin
                    acc_next = ram_rdata;
                    flags_next[7] = ram_rdata[7];
                    flags_next[1] = ram_rdata == 8'd0;
                end else begin
                    flags_next = (ram_rdata & 8'hCF) | (flags_reg & c6502eu_pkg::FLAG_B)
                                 | c6502eu_pkg::FLAG_U;
                end
            end
        end else if (state_reg == c6502eu_pkg::ST_JSR) begin
            finish = out_free;
            if (out_free) begin
                ram_we    = 1'b1;
                ram_wdata = ret_pc[7:0];
                sp_next   = sp_reg - 8'd1;
                res_next.pc_out = d.address;
            end
        end else if (accept) begin
            case (d.op)
                c6502eu_pkg::OP_ADC: begin
                    sum = {1'b0, acc_reg} + {1'b0, m} + {8'd0, cin};
                    v   = sum[7:0];
                    flags_next[6] = ~(acc_reg[7] ^ m[7]) & (acc_reg[7] ^ v[7]);
                    flags_next[0] = sum[8];
                    acc_next = v;
                    res8 = v;
                end
                c6502eu_pkg::OP_AND: begin acc_next = acc_reg & m; res8 = acc_next; end
                c6502eu_pkg::OP_EOR: begin acc_next = acc_reg ^ m; res8 = acc_next; end
                c6502eu_pkg::OP_ORA: begin acc_next = acc_reg | m; res8 = acc_next; end
                c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR,
                c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR: begin
                    v = d.on_accumulator ? acc_reg : m;
                    case (d.op)
                        c6502eu_pkg::OP_ASL: begin flags_next[0] = v[7]; r = {v[6:0], 1'b0}; end
                        c6502eu_pkg::OP_LSR: begin flags_next[0] = v[0]; r = {1'b0, v[7:1]}; end
                        c6502eu_pkg::OP_ROL: begin flags_next[0] = v[7]; r = {v[6:0], cin}; end
                        default: begin flags_next[0] = v[0]; r = {cin, v[7:1]}; end
                    endcase
                    res8 = r;
                    if (d.on_accumulator) begin
                        acc_next = r;
                    end else begin
                        res_next.mem_write = 1'b1;
                        res_next.mem_data  = r;
                    end
                end
                c6502eu_pkg::OP_BCC: take = !flags_reg[0];
                c6502eu_pkg::OP_BCS: take = flags_reg[0];
                c6502eu_pkg::OP_BEQ: take = flags_reg[1];
                c6502eu_pkg::OP_BNE: take = !flags_reg[1];
                c6502eu_pkg::OP_BMI: take = flags_reg[7];
                c6502eu_pkg::OP_BPL: take = !flags_reg[7];
                c6502eu_pkg::OP_BVC: take = !flags_reg[6];
                c6502eu_pkg::OP_BVS: take = flags_reg[6];
                c6502eu_pkg::OP_CLC: flags_next[0] = 1'b0;
                c6502eu_pkg::OP_CLD: flags_next[3] = 1'b0;
                c6502eu_pkg::OP_CLI: flags_next[2] = 1'b0;
                c6502eu_pkg::OP_CLV: flags_next[6] = 1'b0;
                c6502eu_pkg::OP_SEC: flags_next[0] = 1'b1;
                c6502eu_pkg::OP_SED: flags_next[3] = 1'b1;
                c6502eu_pkg::OP_SEI: flags_next[2] = 1'b1;
                c6502eu_pkg::OP_CMP, c6502eu_pkg::OP_CPX, c6502eu_pkg::OP_CPY: begin
                    v = (d.op == c6502eu_pkg::OP_CMP) ? acc_reg :
                        (d.op == c6502eu_pkg::OP_CPX) ? x_reg : y_reg;
                    r = v - m;
                    flags_next[0] = v >= m;
                    flags_next[1] = v == m;
                    flags_next[7] = r[7];
                end
                c6502eu_pkg::OP_DEC, c6502eu_pkg::OP_INC: begin
                    r = (d.op == c6502eu_pkg::OP_DEC) ? m - 8'd1 : m + 8'd1;
                    res8 = r;
                    res_next.mem_write = 1'b1;
                    res_next.mem_data  = r;
                end
                c6502eu_pkg::OP_DEX: begin x_next = x_reg - 8'd1; res8 = x_next; end
                c6502eu_pkg::OP_DEY: begin y_next = y_reg - 8'd1; res8 = y_next; end
                c6502eu_pkg::OP_INX: begin x_next = x_reg + 8'd1; res8 = x_next; end
                c6502eu_pkg::OP_INY: begin y_next = y_reg + 8'd1; res8 = y_next; end
                c6502eu_pkg::OP_JMP: res_next.pc_out = d.address;
                c6502eu_pkg::OP_JSR: begin
                    // push high byte now, low byte from ST_JSR
                    ram_we    = 1'b1;
                    ram_wdata = 8'(16'(d.next_pc_in - 16'd1) >> 8);
                    sp_next   = sp_reg - 8'd1;
                end
                c6502eu_pkg::OP_LDA: begin acc_next = m; res8 = m; end
                c6502eu_pkg::OP_LDX: begin x_next = m; res8 = m; end
                c6502eu_pkg::OP_LDY: begin y_next = m; res8 = m; end
                c6502eu_pkg::OP_PHA: begin
                    ram_we = 1'b1; ram_wdata = acc_reg; sp_next = sp_reg - 8'd1;
                end
                c6502eu_pkg::OP_PHP: begin
                    ram_we = 1'b1; sp_next = sp_reg - 8'd1;
                    ram_wdata = flags_reg | c6502eu_pkg::FLAG_B | c6502eu_pkg::FLAG_U;
                end
                c6502eu_pkg::OP_STA: begin res_next.mem_write = 1'b1; res_next.mem_data = acc_reg; end
                c6502eu_pkg::OP_STX: begin res_next.mem_write = 1'b1; res_next.mem_data = x_reg; end
                c6502eu_pkg::OP_STY: begin res_next.mem_write = 1'b1; res_next.mem_data = y_reg; end
                c6502eu_pkg::OP_TAX: begin x_next = acc_reg; res8 = acc_reg; end
                c6502eu_pkg::OP_TAY: begin y_next = acc_reg; res8 = acc_reg; end
                c6502eu_pkg::OP_TSX: begin x_next = sp_reg; res8 = sp_reg; end
                c6502eu_pkg::OP_TXA: begin acc_next = x_reg; res8 = x_reg; end
                c6502eu_pkg::OP_TYA: begin acc_next = y_reg; res8 = y_reg; end
                c6502eu_pkg::OP_TXS: sp_next = x_reg;
                default: ;
            endcase
            case (d.op)
                c6502eu_pkg::OP_ADC, c6502eu_pkg::OP_AND, c6502eu_pkg::OP_EOR,
                c6502eu_pkg::OP_ORA, c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR,
                c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR, c6502eu_pkg::OP_DEC,
                c6502eu_pkg::OP_INC, c6502eu_pkg::OP_DEX, c6502eu_pkg::OP_DEY,
                c6502eu_pkg::OP_INX, c6502eu_pkg::OP_INY, c6502eu_pkg::OP_LDA,
                c6502eu_pkg::OP_LDX, c6502eu_pkg::OP_LDY, c6502eu_pkg::OP_TAX,
                c6502eu_pkg::OP_TAY, c6502eu_pkg::OP_TSX, c6502eu_pkg::OP_TXA,
                c6502eu_pkg::OP_TYA: begin
                    flags_next[7] = res8[7];
                    flags_next[1] = res8 == 8'd0;
                end
                default: ;
            endcase
            if (take) res_next.pc_out = d.next_pc_in + {{8{m[7]}}, m};
            finish = !(d.op == c6502eu_pkg::OP_PLA || d.op == c6502eu_pkg::OP_PLP
                       || d.op == c6502eu_pkg::OP_JSR);
        end
        flags_next = flags_next | c6502eu_pkg::FLAG_U;
        res_next.acc_out   = acc_next;
        res_next.x_out     = x_next;
        res_next.y_out     = y_next;
        res_next.sp_out    = sp_next;
        res_next.flags_out = flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            sp_reg        <= 8'hFF;
            flags_reg     <= c6502eu_pkg::FLAG_U;
            state_reg     <= c6502eu_pkg::ST_RUN;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            acc_reg   <= acc_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            sp_reg    <= sp_next;
            flags_reg <= flags_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) hold_reg <= s_data;
        if (finish) out_reg <= res_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `EU_ASSERT_IMPL(a_no_accept_clear, aclk, aresetn, clearing, !s_ready, "item accepted during clear")
    `EU_ASSERT_NEXT(a_pull_waits, aclk, aresetn, accept && (s_data.op == c6502eu_pkg::OP_PLA || s_data.op == c6502eu_pkg::OP_PLP), state_reg == c6502eu_pkg::ST_PULL, "pull did not wait for stack read")
    `EU_ASSERT_IMPL(a_u_set, aclk, aresetn, m_valid, m_data.flags_out[5], "status bit 5 cleared")
endmodule

FILE: test/tb.sv
// Self-checking testbench for the 6502 execute unit: random programs against a local predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    c6502eu_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    c6502eu_pkg::out_item_t m_data;

    cpu_6502_execute_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // predictor copy of the architectural state
    logic [7:0] p_acc, p_x, p_y, p_sp, p_flags;
    logic [7:0] p_stack [256];

    c6502eu_pkg::in_item_t  pending_items[$];
    c6502eu_pkg::out_item_t expected_results[$];
    int errors = 0;
    int hold_off = 0;       // long receiver stall, counted in the monitor

    function automatic void put_flag(logic [7:0] bit_mask, bit on);
        if (on) p_flags = p_flags | bit_mask;
        else p_flags = p_flags & ~bit_mask;
    endfunction

    function automatic void set_nz(logic [7:0] v);
        put_flag(c6502eu_pkg::FLAG_Z, v == 8'h00);
        put_flag(c6502eu_pkg::FLAG_N, v[7]);
    endfunction

    function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
        logic [7:0] d;
        d = r - m;
        put_flag(c6502eu_pkg::FLAG_C, r >= m);
        put_flag(c6502eu_pkg::FLAG_Z, r == m);
        put_flag(c6502eu_pkg::FLAG_N, d[7]);
    endfunction

    function automatic void push_stack(logic [7:0] v);
        p_stack[p_sp] = v;
        p_sp = p_sp - 8'd1;
    endfunction

    function automatic logic [7:0] pull_stack();
        p_sp = p_sp + 8'd1;
        return p_stack[p_sp];
    endfunction

    function automatic c6502eu_pkg::out_item_t execute_op(c6502eu_pkg::in_item_t it);
        c6502eu_pkg::out_item_t r;
        logic [7:0] m, v, shifted;
        logic [8:0] sum;
        logic [15:0] ret;
        bit take, is_branch, cin;
        m = it.operand;
        r = '0;
        r.pc_out = it.next_pc_in;
        take = 0;
        is_branch = 0;
        case (c6502eu_pkg::op_t'(it.op))
            c6502eu_pkg::OP_ADC: begin
                sum = {1'b0, p_acc} + {1'b0, m} + {8'd0, p_flags[0]};
                v = sum[7:0];
                put_flag(c6502eu_pkg::FLAG_V, (~(p_acc ^ m) & (p_acc ^ v) & 8'h80) != 0);
                put_flag(c6502eu_pkg::FLAG_C, sum[8]);
                p_acc = v;
                set_nz(p_acc);
            end
            c6502eu_pkg::OP_AND: begin p_acc = p_acc & m; set_nz(p_acc); end
            c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR,
            c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR: begin
                v = it.on_accumulator ? p_acc : m;
                cin = p_flags[0];
                case (c6502eu_pkg::op_t'(it.op))
                    c6502eu_pkg::OP_ASL: begin
                        put_flag(c6502eu_pkg::FLAG_C, v[7]); shifted = v << 1;
                    end
                    c6502eu_pkg::OP_LSR: begin
                        put_flag(c6502eu_pkg::FLAG_C, v[0]); shifted = v >> 1;
                    end
                    c6502eu_pkg::OP_ROL: begin
                        put_flag(c6502eu_pkg::FLAG_C, v[7]); shifted = {v[6:0], cin};
                    end
                    default: begin
                        put_flag(c6502eu_pkg::FLAG_C, v[0]); shifted = {cin, v[7:1]};
                    end
                endcase
                set_nz(shifted);
                if (it.on_accumulator) p_acc = shifted;
                else begin r.mem_write = 1; r.mem_data = shifted; end
            end
            c6502eu_pkg::OP_BCC: begin is_branch = 1; take = !p_flags[0]; end
            c6502eu_pkg::OP_BCS: begin is_branch = 1; take = p_flags[0]; end
            c6502eu_pkg::OP_BEQ: begin is_branch = 1; take = p_flags[1]; end
            c6502eu_pkg::OP_BMI: begin is_branch = 1; take = p_flags[7]; end
            c6502eu_pkg::OP_BNE: begin is_branch = 1; take = !p_flags[1]; end
            c6502eu_pkg::OP_BVC: begin is_branch = 1; take = !p_flags[6]; end
            c6502eu_pkg::OP_BVS: begin is_branch = 1; take = p_flags[6]; end
            c6502eu_pkg::OP_BPL: begin is_branch = 1; take = !p_flags[7]; end
            c6502eu_pkg::OP_CLC: put_flag(c6502eu_pkg::FLAG_C, 0);
            c6502eu_pkg::OP_CLD: put_flag(c6502eu_pkg::FLAG_D, 0);
            c6502eu_pkg::OP_CLI: put_flag(c6502eu_pkg::FLAG_I, 0);
            c6502eu_pkg::OP_CLV: put_flag(c6502eu_pkg::FLAG_V, 0);
            c6502eu_pkg::OP_CMP: compare_reg(p_acc, m);
            c6502eu_pkg::OP_CPX: compare_reg(p_x, m);
            c6502eu_pkg::OP_CPY: compare_reg(p_y, m);
            c6502eu_pkg::OP_DEC: begin
                v = m - 8'd1; set_nz(v); r.mem_write = 1; r.mem_data = v;
            end
            c6502eu_pkg::OP_DEX: begin p_x = p_x - 8'd1; set_nz(p_x); end
            c6502eu_pkg::OP_DEY: begin p_y = p_y - 8'd1; set_nz(p_y); end
            c6502eu_pkg::OP_EOR: begin p_acc = p_acc ^ m; set_nz(p_acc); end
            c6502eu_pkg::OP_INC: begin
                v = m + 8'd1; set_nz(v); r.mem_write = 1; r.mem_data = v;
            end
            c6502eu_pkg::OP_INX: begin p_x = p_x + 8'd1; set_nz(p_x); end
            c6502eu_pkg::OP_INY: begin p_y = p_y + 8'd1; set_nz(p_y); end
            c6502eu_pkg::OP_JMP: r.pc_out = it.address;
            c6502eu_pkg::OP_JSR: begin
                ret = it.next_pc_in - 16'd1;
                push_stack(ret[15:8]);
                push_stack(ret[7:0]);
                r.pc_out = it.address;
            end
            c6502eu_pkg::OP_LDA: begin p_acc = m; set_nz(p_acc); end
            c6502eu_pkg::OP_LDX: begin p_x = m; set_nz(p_x); end
            c6502eu_pkg::OP_LDY: begin p_y = m; set_nz(p_y); end
            c6502eu_pkg::OP_ORA: begin p_acc = p_acc | m; set_nz(p_acc); end
            c6502eu_pkg::OP_PHA: push_stack(p_acc);
            c6502eu_pkg::OP_PHP:
                push_stack(p_flags | c6502eu_pkg::FLAG_B | c6502eu_pkg::FLAG_U);
            c6502eu_pkg::OP_PLA: begin p_acc = pull_stack(); set_nz(p_acc); end
            c6502eu_pkg::OP_PLP: begin
                v = pull_stack();
                p_flags = (v & ~(c6502eu_pkg::FLAG_B | c6502eu_pkg::FLAG_U))
                          | (p_flags & c6502eu_pkg::FLAG_B) | c6502eu_pkg::FLAG_U;
            end
            c6502eu_pkg::OP_SEC: put_flag(c6502eu_pkg::FLAG_C, 1);
            c6502eu_pkg::OP_SED: put_flag(c6502eu_pkg::FLAG_D, 1);
            c6502eu_pkg::OP_SEI: put_flag(c6502eu_pkg::FLAG_I, 1);
            c6502eu_pkg::OP_STA: begin r.mem_write = 1; r.mem_data = p_acc; end
            c6502eu_pkg::OP_STX: begin r.mem_write = 1; r.mem_data = p_x; end
            c6502eu_pkg::OP_STY: begin r.mem_write = 1; r.mem_data = p_y; end
            c6502eu_pkg::OP_TAX: begin p_x = p_acc; set_nz(p_x); end
            c6502eu_pkg::OP_TAY: begin p_y = p_acc; set_nz(p_y); end
            c6502eu_pkg::OP_TSX: begin p_x = p_sp; set_nz(p_x); end
            c6502eu_pkg::OP_TXA: begin p_acc = p_x; set_nz(p_acc); end
            c6502eu_pkg::OP_TXS: p_sp = p_x;
            c6502eu_pkg::OP_TYA: begin p_acc = p_y; set_nz(p_acc); end
            default: ;
        endcase
        if (is_branch && take) r.pc_out = it.next_pc_in + {{8{m[7]}}, m};
        p_flags = p_flags | c6502eu_pkg::FLAG_U;
        r.acc_out = p_acc;
        r.x_out = p_x;
        r.y_out = p_y;
        r.sp_out = p_sp;
        r.flags_out = p_flags;
        return r;
    endfunction

    function automatic c6502eu_pkg::in_item_t make_item(logic [5:0] op, logic [7:0] operand);
        c6502eu_pkg::in_item_t it;
        it.op = op;
        it.operand = operand;
        it.address = 16'($urandom);
        it.next_pc_in = 16'($urandom);
        it.on_accumulator = 1'($urandom);
        return it;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(execute_op(s_data));
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 1) == 0) send_gap = 0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int recv_gap = 0;
    int accepted_count = 0;
    always @(posedge aclk) begin
        c6502eu_pkg::out_item_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                accepted_count++;
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.mem_write !== exp_r.mem_write) begin
                        $error("mem_write exp %h got %h", exp_r.mem_write, m_data.mem_write);
                        errors++;
                    end
                    if (m_data.mem_data !== exp_r.mem_data) begin
                        $error("mem_data exp %h got %h", exp_r.mem_data, m_data.mem_data);
                        errors++;
                    end
                    if (m_data.pc_out !== exp_r.pc_out) begin
                        $error("pc_out exp %h got %h", exp_r.pc_out, m_data.pc_out);
                        errors++;
                    end
                    if (m_data.acc_out !== exp_r.acc_out) begin
                        $error("acc_out exp %h got %h", exp_r.acc_out, m_data.acc_out);
                        errors++;
                    end
                    if (m_data.x_out !== exp_r.x_out) begin
                        $error("x_out exp %h got %h", exp_r.x_out, m_data.x_out);
                        errors++;
                    end
                    if (m_data.y_out !== exp_r.y_out) begin
                        $error("y_out exp %h got %h", exp_r.y_out, m_data.y_out);
                        errors++;
                    end
                    if (m_data.sp_out !== exp_r.sp_out) begin
                        $error("sp_out exp %h got %h", exp_r.sp_out, m_data.sp_out);
                        errors++;
                    end
                    if (m_data.flags_out !== exp_r.flags_out) begin
                        $error("flags_out exp %h got %h", exp_r.flags_out, m_data.flags_out);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 16);
                // one long stall partway through the random part
                if (accepted_count == 300) hold_off = 400;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        int kind;
        logic [5:0] op;
        p_acc = 0; p_x = 0; p_y = 0; p_sp = 8'hFF; p_flags = c6502eu_pkg::FLAG_U;
        foreach (p_stack[i]) p_stack[i] = 8'h00;

        // directed: adc overflow/carry, compares, stack wrap, plp bits, branches, jsr, rotates, undefined codes
        pending_items.push_back(make_item(c6502eu_pkg::OP_LDA, 8'h7F));
        pending_items.push_back(make_item(c6502eu_pkg::OP_ADC, 8'h01));
        pending_items.push_back(make_item(c6502eu_pkg::OP_ADC, 8'hFF));
        pending_items.push_back(make_item(c6502eu_pkg::OP_CMP, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_CPX, 8'hFF));
        pending_items.push_back(make_item(c6502eu_pkg::OP_CPY, 8'h80));
        pending_items.push_back(make_item(c6502eu_pkg::OP_BVS, 8'h80));
        pending_items.push_back(make_item(c6502eu_pkg::OP_BCC, 8'h7F));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PLA, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_LDA, 8'hFF));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PHA, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PLP, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PHP, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_JSR, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PLA, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PLA, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_LDX, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_TXS, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_PHA, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_TSX, 8'h00));
        pending_items.push_back(make_item(c6502eu_pkg::OP_ROR, 8'h01));
        pending_items.push_back(make_item(c6502eu_pkg::OP_ROL, 8'h80));
        pending_items.push_back(make_item(6'd63, 8'hFF));
        pending_items.push_back(make_item(6'd51, 8'h00));

        // random: mostly legal ops, some undefined codes, extra weight on stack ops
        for (k = 0; k < 1700; k++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) op = 6'($urandom_range(51, 63));
            else if (kind < 5) begin
                case ($urandom_range(0, 4))
                    0: op = c6502eu_pkg::OP_PHA;
                    1: op = c6502eu_pkg::OP_PHP;
                    2: op = c6502eu_pkg::OP_PLA;
                    3: op = c6502eu_pkg::OP_PLP;
                    default: op = c6502eu_pkg::OP_JSR;
                endcase
            end else op = 6'($urandom_range(0, 50));
            pending_items.push_back(make_item(op, 8'($urandom)));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/c6502eu_pkg.sv
rtl/core/c6502eu_ram.sv
rtl/core/cpu_6502_execute_unit.sv
test/tb.sv
